@@ design/q2e_pkg.sv @@
// Shared types, widths and constants for the quaternion to Euler angle unit.
`default_nettype none
package q2e_pkg;

  localparam int Q_W    = 16;
  localparam int P_W    = 32;
  localparam int S_W    = 34;
  localparam int SQ_W   = 57;
  localparam int RT_W   = 58;
  localparam int ROOT_W = 29;
  localparam int SQRT_CELLS = 29;
  localparam int CX_W   = 37;
  localparam int CZ_W   = 35;

  localparam logic signed [S_W-1:0]  ONE_Q28  = 34'sd268435456;
  localparam logic signed [S_W-1:0]  MONE_Q28 = -34'sd268435456;
  localparam logic [SQ_W-1:0]        FULL_SQ  = 57'h100000000000000;
  localparam logic signed [CZ_W-1:0] PI_Q30   = 35'sd3373259426;
  localparam logic signed [15:0]     PI_Q13      = 16'sd25736;
  localparam logic signed [15:0]     HALF_PI_Q13 = 16'sd12868;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [S_W-1:0] sr;
    logic signed [S_W-1:0] cr;
    logic signed [S_W-1:0] sp;
    logic signed [S_W-1:0] sy;
    logic signed [S_W-1:0] cy;
    logic                  hi;
    logic                  lo;
  } side_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
    logic                   zero;
    logic                   hi;
    logic                   lo;
  } vec_t;

endpackage
`default_nettype wire

@@ design/quaternion_to_euler_unit.sv @@
// Quaternion to roll, pitch and yaw converter, top level.
//
// The input channel takes one word per quaternion (w, x, y, z, signed Q2.14);
// the output channel returns one word of roll, pitch and yaw in radians,
// signed Q3.13. Both channels use valid and ready.
// A new quaternion can be taken in every clock cycle while in_ready is high.
// From acceptance to the result being shown, a word passes in order through
// the products, the sums, the squaring of the pitch term, the forming of
// the radicand, 29 cells of the bit-serial square root, one pre-rotation,
// CORDIC_STAGES rotation cells for each of the three angles, run in step, and
// the output register with rounding and saturation.
// Reset clears the valid bits of every stage and of the output register.
// When the receiver stalls, the result stays in the output register; the
// pipeline keeps moving and taking input until its last stage holds a word,
// and only then holds still with in_ready low.
`default_nettype none
module quaternion_to_euler_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_roll_angle,
  output logic signed [14:0]      out_pitch_angle,
  output logic signed [15:0]      out_yaw_angle
);

  localparam int DEPTH = 4 + q2e_pkg::SQRT_CELLS + 1 + CORDIC_STAGES;
  localparam int CX_W  = q2e_pkg::CX_W;
  localparam int CZ_W  = q2e_pkg::CZ_W;
  localparam int S_W   = q2e_pkg::S_W;

  logic [DEPTH-1:0] vld_r;
  logic             adv;
  logic             out_valid_r;

  logic signed [q2e_pkg::P_W-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [q2e_pkg::P_W-1:0] p_wy_r, p_zx_r, p_wz_r, p_xy_r;
  q2e_pkg::side_t                 s2_r, s3_r, s4_r;
  q2e_pkg::side_t                 s2_nxt, s3_nxt;
  logic [q2e_pkg::SQ_W-1:0]       sq_r;
  logic [q2e_pkg::SQ_W-1:0]       rem0_r;
  logic signed [28:0]             spm;
  logic signed [57:0]             sq_full;

  logic [q2e_pkg::SQ_W-1:0] rm [q2e_pkg::SQRT_CELLS+1];
  logic [q2e_pkg::RT_W-1:0] rt [q2e_pkg::SQRT_CELLS+1];
  q2e_pkg::side_t           sd [q2e_pkg::SQRT_CELLS+1];

  q2e_pkg::vec_t rv [CORDIC_STAGES+1];
  q2e_pkg::vec_t pv [CORDIC_STAGES+1];
  q2e_pkg::vec_t yv [CORDIC_STAGES+1];

  logic signed [CX_W-1:0] root_x;
  q2e_pkg::vec_t          pitch_pre;

  logic signed [15:0] roll_nxt, yaw_nxt, pitch_nxt;

  function automatic q2e_pkg::vec_t pre_rot(input logic signed [CX_W-1:0] y,
                                            input logic signed [CX_W-1:0] x);
    q2e_pkg::vec_t v;
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    v.zero = (x == '0) && (y == '0);
    v.hi   = 1'b0;
    v.lo   = 1'b0;
    if (x < 0) begin
      v.z = (y >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
      v.x = -x;
      v.y = -y;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] to_q13(input logic signed [CZ_W-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [CZ_W:0]    t;
    logic signed [CZ_W-17:0] r;
    logic signed [CZ_W-17:0] l;
    t = (CZ_W+1)'(z) + (CZ_W+1)'(65536);
    r = $signed(t[CZ_W:17]);
    l = (CZ_W-16)'(lim);
    if (r > l) begin
      r = l;
    end else if (r < -l) begin
      r = -l;
    end
    return r[15:0];
  endfunction

  assign adv      = !(out_valid_r && !out_ready && vld_r[DEPTH-1]);
  assign in_ready = adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    s2_nxt.sr = (S_W'(p_wx_r) + S_W'(p_yz_r)) <<< 1;
    s2_nxt.cr = q2e_pkg::ONE_Q28 - ((S_W'(p_xx_r) + S_W'(p_yy_r)) <<< 1);
    s2_nxt.sp = (S_W'(p_wy_r) - S_W'(p_zx_r)) <<< 1;
    s2_nxt.sy = (S_W'(p_wz_r) + S_W'(p_xy_r)) <<< 1;
    s2_nxt.cy = q2e_pkg::ONE_Q28 - ((S_W'(p_yy_r) + S_W'(p_zz_r)) <<< 1);
    s2_nxt.hi = 1'b0;
    s2_nxt.lo = 1'b0;

    s3_nxt    = s2_r;
    s3_nxt.hi = s2_r.sp >= q2e_pkg::ONE_Q28;
    s3_nxt.lo = s2_r.sp <= q2e_pkg::MONE_Q28;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx_r <= in_quat_w * in_quat_x;
      p_yz_r <= in_quat_y * in_quat_z;
      p_xx_r <= in_quat_x * in_quat_x;
      p_yy_r <= in_quat_y * in_quat_y;
      p_zz_r <= in_quat_z * in_quat_z;
      p_wy_r <= in_quat_w * in_quat_y;
      p_zx_r <= in_quat_z * in_quat_x;
      p_wz_r <= in_quat_w * in_quat_z;
      p_xy_r <= in_quat_x * in_quat_y;

      s2_r <= s2_nxt;

      s3_r <= s3_nxt;
      sq_r <= sq_full[q2e_pkg::SQ_W-1:0];

      s4_r   <= s3_r;
      rem0_r <= q2e_pkg::FULL_SQ - sq_r;
    end
  end

  assign spm     = $signed(s2_r.sp[28:0]);
  assign sq_full = spm * spm;

  assign rm[0] = rem0_r;
  assign rt[0] = '0;
  assign sd[0] = s4_r;

  for (genvar i = 0; i < q2e_pkg::SQRT_CELLS; i++) begin : g_sqrt
    q2e_sqrt_cell #(
      .K(q2e_pkg::SQRT_CELLS - 1 - i)
    ) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (rm[i]),
      .root_i (rt[i]),
      .side_i (sd[i]),
      .rem_r  (rm[i+1]),
      .root_r (rt[i+1]),
      .side_r (sd[i+1])
    );
  end

  assign root_x = $signed({{(CX_W-q2e_pkg::ROOT_W){1'b0}},
                           rt[q2e_pkg::SQRT_CELLS][q2e_pkg::ROOT_W-1:0]});

  always_comb begin
    pitch_pre    = pre_rot(CX_W'(sd[q2e_pkg::SQRT_CELLS].sp), root_x);
    pitch_pre.hi = sd[q2e_pkg::SQRT_CELLS].hi;
    pitch_pre.lo = sd[q2e_pkg::SQRT_CELLS].lo;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rv[0] <= pre_rot(CX_W'(sd[q2e_pkg::SQRT_CELLS].sr), CX_W'(sd[q2e_pkg::SQRT_CELLS].cr));
      pv[0] <= pitch_pre;
      yv[0] <= pre_rot(CX_W'(sd[q2e_pkg::SQRT_CELLS].sy), CX_W'(sd[q2e_pkg::SQRT_CELLS].cy));
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(.I(i)) u_roll (
      .clk (clk), .en (adv), .vec_i (rv[i]), .vec_r (rv[i+1])
    );
    q2e_cordic_cell #(.I(i)) u_pitch (
      .clk (clk), .en (adv), .vec_i (pv[i]), .vec_r (pv[i+1])
    );
    q2e_cordic_cell #(.I(i)) u_yaw (
      .clk (clk), .en (adv), .vec_i (yv[i]), .vec_r (yv[i+1])
    );
  end

  always_comb begin
    roll_nxt = rv[CORDIC_STAGES].zero ? 16'sd0 :
               to_q13(rv[CORDIC_STAGES].z, q2e_pkg::PI_Q13);
    yaw_nxt  = yv[CORDIC_STAGES].zero ? 16'sd0 :
               to_q13(yv[CORDIC_STAGES].z, q2e_pkg::PI_Q13);
    if (pv[CORDIC_STAGES].hi) begin
      pitch_nxt = q2e_pkg::HALF_PI_Q13;
    end else if (pv[CORDIC_STAGES].lo) begin
      pitch_nxt = -q2e_pkg::HALF_PI_Q13;
    end else if (pv[CORDIC_STAGES].zero) begin
      pitch_nxt = 16'sd0;
    end else begin
      pitch_nxt = to_q13(pv[CORDIC_STAGES].z, q2e_pkg::HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_roll_angle  <= roll_nxt;
      out_pitch_angle <= pitch_nxt[14:0];
      out_yaw_angle   <= yaw_nxt;
    end
  end

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && vld_r[DEPTH-1]))
    else $error("input refused without a stalled full output");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 15'sd12868 && out_pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736))
    else $error("roll out of range");

endmodule
`default_nettype wire

@@ design/q2e_sqrt_cell.sv @@
// One digit cell of the pipelined integer square root, carrying side data along.
`default_nettype none
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [q2e_pkg::SQ_W-1:0]    rem_i,
  input  wire logic [q2e_pkg::RT_W-1:0]    root_i,
  input  wire q2e_pkg::side_t              side_i,
  output logic      [q2e_pkg::SQ_W-1:0]    rem_r,
  output logic      [q2e_pkg::RT_W-1:0]    root_r,
  output q2e_pkg::side_t                   side_r
);

  localparam logic [q2e_pkg::RT_W-1:0] BIT = q2e_pkg::RT_W'(1) << (2 * K);

  logic [q2e_pkg::RT_W-1:0] trial;
  logic                     ge;
  logic [q2e_pkg::SQ_W-1:0] rem_nxt;
  logic [q2e_pkg::RT_W-1:0] root_nxt;

  always_comb begin
    trial = root_i + BIT;
    ge    = {1'b0, rem_i} >= trial;
    if (ge) begin
      rem_nxt  = rem_i - trial[q2e_pkg::SQ_W-1:0];
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

endmodule
`default_nettype wire

@@ design/q2e_cordic_cell.sv @@
// One micro-rotation cell of the vectoring CORDIC used for atan2.
`default_nettype none
module q2e_cordic_cell #(
  parameter int I = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire q2e_pkg::vec_t  vec_i,
  output q2e_pkg::vec_t       vec_r
);

  localparam logic signed [q2e_pkg::CZ_W-1:0] ANG =
    $signed({3'b000, q2e_pkg::ATAN_Q30[I]});

  logic signed [q2e_pkg::CX_W-1:0] xs;
  logic signed [q2e_pkg::CX_W-1:0] ys;
  q2e_pkg::vec_t                   vec_nxt;

  always_comb begin
    xs      = vec_i.x >>> I;
    ys      = vec_i.y >>> I;
    vec_nxt = vec_i;
    if (vec_i.y > 0) begin
      vec_nxt.x = vec_i.x + ys;
      vec_nxt.y = vec_i.y - xs;
      vec_nxt.z = vec_i.z + ANG;
    end else begin
      vec_nxt.x = vec_i.x - ys;
      vec_nxt.y = vec_i.y + xs;
      vec_nxt.z = vec_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule
`default_nettype wire
